>>> rtl/trme_pkg.sv
// Package for the register machine execute core: sizes, opcode and status codes,
// write-port structs and memory controller state type. No dependencies.
`default_nettype none

package trme_pkg;

   localparam int MEM_DEPTH  = 256;
   localparam int NUM_REGS   = 12;
   localparam int DATA_W     = 32;
   localparam int REG_IDX_W  = $clog2(NUM_REGS);
   localparam int DM_ADDR_W  = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam int MEM_ADDR_W = 16;

   localparam int REQ_TDATA_W = 64;
   localparam int RSP_TDATA_W = 40;

   localparam logic [REG_IDX_W-1:0]  LAST_REG     = REG_IDX_W'(NUM_REGS - 1);
   localparam logic [DM_ADDR_W-1:0]  DM_LAST_ADDR = DM_ADDR_W'(MEM_DEPTH - 1);
   localparam logic [MEM_ADDR_W:0]   MEM_LIMIT    = (MEM_ADDR_W + 1)'(MEM_DEPTH);

   localparam logic [2:0] OP_ADD  = 3'd0;
   localparam logic [2:0] OP_SUB  = 3'd1;
   localparam logic [2:0] OP_LDR  = 3'd2;
   localparam logic [2:0] OP_STR  = 3'd3;
   localparam logic [2:0] OP_HALT = 3'd4;

   localparam logic [2:0] ST_DONE     = 3'd0;
   localparam logic [2:0] ST_BAD_REG  = 3'd1;
   localparam logic [2:0] ST_BAD_ADDR = 3'd2;
   localparam logic [2:0] ST_HALTED   = 3'd3;
   localparam logic [2:0] ST_STOPPED  = 3'd4;

   typedef struct packed {
      logic                 en;
      logic [REG_IDX_W-1:0] idx;
      logic [DATA_W-1:0]    data;
   } rf_wr_type;

   typedef struct packed {
      logic                 en;
      logic [DM_ADDR_W-1:0] addr;
      logic [DATA_W-1:0]    data;
   } dm_wr_type;

   typedef enum logic [1:0] {
      DM_CLEAR = 2'b01,
      DM_RUN   = 2'b10
   } dm_state_type;

endpackage

`default_nettype wire

>>> rtl/trme_regfile.sv
// Register file: twelve words in a small memory, two registered read ports, one write.
// Per-entry valid bits give the reset contents (entry i reads as i). Uses trme_pkg.
`default_nettype none

module trme_regfile
   import trme_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 rd_en,
   input  wire logic [REG_IDX_W-1:0] rd_a_idx,
   input  wire logic [REG_IDX_W-1:0] rd_b_idx,
   output logic      [DATA_W-1:0]    rd_a_data,
   output logic      [DATA_W-1:0]    rd_b_data,
   input  wire rf_wr_type            wr
);

   logic [DATA_W-1:0]    mem [NUM_REGS];
   logic [NUM_REGS-1:0]  vld_ff;
   logic [NUM_REGS-1:0]  vld_in;
   logic [DATA_W-1:0]    a_data_ff;
   logic [DATA_W-1:0]    b_data_ff;
   logic                 a_vld_ff;
   logic                 b_vld_ff;
   logic [REG_IDX_W-1:0] a_idx_ff;
   logic [REG_IDX_W-1:0] b_idx_ff;

   always_comb begin
      vld_in = vld_ff;
      if (wr.en) begin
         vld_in[wr.idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.idx] <= wr.data;
      end
      if (rd_en) begin
         a_data_ff <= mem[rd_a_idx];
         b_data_ff <= mem[rd_b_idx];
         a_vld_ff  <= vld_ff[rd_a_idx];
         b_vld_ff  <= vld_ff[rd_b_idx];
         a_idx_ff  <= rd_a_idx;
         b_idx_ff  <= rd_b_idx;
      end
   end

   assign rd_a_data = a_vld_ff ? a_data_ff : DATA_W'(a_idx_ff);
   assign rd_b_data = b_vld_ff ? b_data_ff : DATA_W'(b_idx_ff);

endmodule

`default_nettype wire

>>> rtl/trme_datamem.sv
// Data memory: MEM_DEPTH words, one registered read port and one write port.
// Runs a zero-fill pass after reset before reporting ready. Uses trme_pkg.
`default_nettype none

module trme_datamem
   import trme_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   output logic                      ready,
   input  wire logic                 rd_en,
   input  wire logic [DM_ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0]    rd_data,
   input  wire dm_wr_type            wr
);

   logic [DATA_W-1:0]    mem [MEM_DEPTH];
   dm_state_type         state_ff;
   dm_state_type         state_in;
   logic [DM_ADDR_W-1:0] clr_addr_ff;
   logic [DM_ADDR_W-1:0] clr_addr_in;
   logic [DATA_W-1:0]    rd_data_ff;
   logic                 mem_we;
   logic [DM_ADDR_W-1:0] mem_waddr;
   logic [DATA_W-1:0]    mem_wdata;

   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      mem_we      = 1'b0;
      mem_waddr   = wr.addr;
      mem_wdata   = wr.data;
      unique case (state_ff)
         DM_CLEAR: begin
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            mem_wdata   = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == DM_LAST_ADDR) begin
               state_in = DM_RUN;
            end
         end
         DM_RUN: begin
            mem_we = wr.en;
         end
         default: begin
            state_in = DM_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= DM_CLEAR;
         clr_addr_ff <= '0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign ready   = (state_ff == DM_RUN);
   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/tiny_register_machine_execute_core.sv
// Execute core of a small load/store register machine: decode, operand read,
// execute/writeback with forwarding, registered result. Uses trme_pkg,
// trme_regfile and trme_datamem.
//
//   channel | dir | tdata (low bit up)                                        | tuser
//   req     | in  | operation[2:0] target_reg[6:3] first_reg[10:7]           | operand_is_literal
//           |     | operand_value[42:11] mem_address[58:43], zero to 63      |
//   rsp     | out | status[2:0] result_value[34:3], zero to 39               | -
//
// One instruction per cycle sustained while rsp is not stalled; each req beat passes the
// memory read into the execute stage, then execute into the result register, before its rsp beat.
// After reset req_tready stays low while the data memory zero-fill runs.
// Register and memory writes of one instruction are forwarded to the next one's reads.
// A stalled rsp holds its beat; the execute stage still takes one more instruction.
`default_nettype none

module tiny_register_machine_execute_core
   import trme_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // operation, target_reg, first_reg, operand_value, mem_address
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // operand_is_literal
   input  wire logic [0:0]             req_tuser,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // status, result_value
   output logic      [RSP_TDATA_W-1:0] rsp_tdata
);

   logic [2:0]            in_op;
   logic [3:0]            in_tgt;
   logic [3:0]            in_src;
   logic [DATA_W-1:0]     in_opv;
   logic [MEM_ADDR_W-1:0] in_addr;
   logic                  in_addr_ok;
   logic                  req_fire;
   logic                  dm_ready;

   logic [REG_IDX_W-1:0]  rd_a_idx;
   logic [REG_IDX_W-1:0]  rd_b_idx;
   logic [DM_ADDR_W-1:0]  rd_dm_addr;
   logic [DATA_W-1:0]     rf_a_data;
   logic [DATA_W-1:0]     rf_b_data;
   logic [DATA_W-1:0]     dm_rd_data;

   logic                  s1_valid_ff;
   logic [2:0]            s1_op_ff;
   logic [3:0]            s1_tgt_ff;
   logic [3:0]            s1_src_ff;
   logic                  s1_lit_ff;
   logic [DATA_W-1:0]     s1_opv_ff;
   logic                  s1_addr_ok_ff;
   logic [DM_ADDR_W-1:0]  s1_dm_addr_ff;
   logic [REG_IDX_W-1:0]  s1_a_idx_ff;
   logic [REG_IDX_W-1:0]  s1_b_idx_ff;
   logic                  s1_fire;
   logic                  s1_valid_in;

   rf_wr_type             fwd_rf_ff;
   dm_wr_type             fwd_dm_ff;
   rf_wr_type             rf_wr;
   dm_wr_type             dm_wr;

   logic                  stopped_ff;
   logic                  stopped_in;

   logic [DATA_W-1:0]     a_val;
   logic [DATA_W-1:0]     b_reg_val;
   logic [DATA_W-1:0]     b_val;
   logic [DATA_W-1:0]     mem_val;
   logic                  src_ok;
   logic                  tgt_ok;
   logic                  opv_ok;
   logic [2:0]            ex_status;
   logic [DATA_W-1:0]     ex_value;

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [2:0]            rsp_status_ff;
   logic [DATA_W-1:0]     rsp_value_ff;

   // decode and operand read
   assign in_op      = req_tdata[2:0];
   assign in_tgt     = req_tdata[6:3];
   assign in_src     = req_tdata[10:7];
   assign in_opv     = req_tdata[42:11];
   assign in_addr    = req_tdata[58:43];
   assign in_addr_ok = ({1'b0, in_addr} < MEM_LIMIT);

   assign s1_fire    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = dm_ready && (!s1_valid_ff || s1_fire);
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      rd_a_idx = '0;
      if (in_op == OP_STR) begin
         if (in_tgt <= LAST_REG) begin
            rd_a_idx = in_tgt;
         end
      end else if (in_src <= LAST_REG) begin
         rd_a_idx = in_src;
      end
      rd_b_idx = '0;
      if (in_opv <= DATA_W'(LAST_REG)) begin
         rd_b_idx = in_opv[REG_IDX_W-1:0];
      end
      rd_dm_addr = in_addr_ok ? in_addr[DM_ADDR_W-1:0] : '0;
   end

   trme_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (req_fire),
      .rd_a_idx  (rd_a_idx),
      .rd_b_idx  (rd_b_idx),
      .rd_a_data (rf_a_data),
      .rd_b_data (rf_b_data),
      .wr        (rf_wr)
   );

   trme_datamem u_datamem (
      .clock   (clock),
      .reset   (reset),
      .ready   (dm_ready),
      .rd_en   (req_fire),
      .rd_addr (rd_dm_addr),
      .rd_data (dm_rd_data),
      .wr      (dm_wr)
   );

   // execute stage
   assign s1_valid_in = req_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_rf_ff   <= '0;
         fwd_dm_ff   <= '0;
         stopped_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         stopped_ff  <= stopped_in;
         if (req_fire) begin
            fwd_rf_ff <= rf_wr;
            fwd_dm_ff <= dm_wr;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff      <= in_op;
         s1_tgt_ff     <= in_tgt;
         s1_src_ff     <= in_src;
         s1_lit_ff     <= req_tuser[0];
         s1_opv_ff     <= in_opv;
         s1_addr_ok_ff <= in_addr_ok;
         s1_dm_addr_ff <= rd_dm_addr;
         s1_a_idx_ff   <= rd_a_idx;
         s1_b_idx_ff   <= rd_b_idx;
      end
   end

   always_comb begin
      a_val     = (fwd_rf_ff.en && fwd_rf_ff.idx == s1_a_idx_ff) ? fwd_rf_ff.data : rf_a_data;
      b_reg_val = (fwd_rf_ff.en && fwd_rf_ff.idx == s1_b_idx_ff) ? fwd_rf_ff.data : rf_b_data;
      b_val     = s1_lit_ff ? s1_opv_ff : b_reg_val;
      mem_val   = (fwd_dm_ff.en && fwd_dm_ff.addr == s1_dm_addr_ff) ? fwd_dm_ff.data
                                                                     : dm_rd_data;
      src_ok    = (s1_src_ff <= LAST_REG);
      tgt_ok    = (s1_tgt_ff <= LAST_REG);
      opv_ok    = (s1_opv_ff <= DATA_W'(LAST_REG));
   end

   always_comb begin
      ex_status  = ST_DONE;
      ex_value   = '0;
      rf_wr.en   = 1'b0;
      rf_wr.idx  = s1_tgt_ff[REG_IDX_W-1:0];
      rf_wr.data = '0;
      dm_wr.en   = 1'b0;
      dm_wr.addr = s1_dm_addr_ff;
      dm_wr.data = a_val;
      if (stopped_ff) begin
         ex_status = ST_STOPPED;
      end else begin
         unique case (s1_op_ff)
            OP_ADD, OP_SUB: begin
               if (!src_ok || (!s1_lit_ff && !opv_ok) || !tgt_ok) begin
                  ex_status = ST_BAD_REG;
               end else begin
                  ex_value = (s1_op_ff == OP_ADD) ? (a_val + b_val) : (a_val - b_val);
                  rf_wr.en = 1'b1;
               end
            end
            OP_LDR: begin
               if (!s1_addr_ok_ff) begin
                  ex_status = ST_BAD_ADDR;
               end else if (!tgt_ok) begin
                  ex_status = ST_BAD_REG;
               end else begin
                  ex_value = mem_val;
                  rf_wr.en = 1'b1;
               end
            end
            OP_STR: begin
               if (!tgt_ok) begin
                  ex_status = ST_BAD_REG;
               end else if (!s1_addr_ok_ff) begin
                  ex_status = ST_BAD_ADDR;
               end else begin
                  ex_value = a_val;
                  dm_wr.en = 1'b1;
               end
            end
            OP_HALT: begin
               ex_status = ST_HALTED;
            end
            default: begin
               ex_status = ST_DONE;
            end
         endcase
      end
      rf_wr.data = ex_value;
      rf_wr.en   = rf_wr.en && s1_fire;
      dm_wr.en   = dm_wr.en && s1_fire;
   end

   assign stopped_in = stopped_ff || (s1_fire && (ex_status == ST_BAD_REG
                                               || ex_status == ST_BAD_ADDR
                                               || ex_status == ST_HALTED));

   // result register
   assign rsp_valid_in = s1_fire ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_status_ff <= ex_status;
         rsp_value_ff  <= ex_value;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - DATA_W - 3)'(0), rsp_value_ff, rsp_status_ff};

`ifndef SYNTHESIS
   a_no_req_during_clear: assert property (@(posedge clock)
      !dm_ready |-> !req_tready)
      else $error("request taken during memory clear");

   a_stopped_sticks: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |=> stopped_ff)
      else $error("stopped flag dropped without reset");

   a_single_write: assert property (@(posedge clock) disable iff (reset)
      !(rf_wr.en && dm_wr.en))
      else $error("register and memory written by one instruction");

   a_stopped_frozen: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |-> !rf_wr.en && !dm_wr.en)
      else $error("state written while stopped");

   a_stage_empty_in_clear: assert property (@(posedge clock) disable iff (reset)
      !dm_ready |-> !s1_valid_ff)
      else $error("execute stage busy during memory clear");
`endif

endmodule

`default_nettype wire

>>> test/trme_execute_checker.sv
`timescale 1ns / 100ps
// Checker for the execute core: watches the req and rsp channels, predicts each result
// beat from its own register file, data memory and stop flag, and counts mismatches.
// Needs trme_pkg.
module trme_execute_checker
   import trme_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   input  wire logic                   req_tready,
   // operation, target_reg, first_reg, operand_value, mem_address
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // operand_is_literal
   input  wire logic [0:0]             req_tuser,
   input  wire logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   // status, result_value
   input  wire logic [RSP_TDATA_W-1:0] rsp_tdata,
   output int                          mismatch_count,
   output int                          outstanding
);

   typedef struct packed {
      logic [2:0]        status;
      logic [DATA_W-1:0] value;
   } retire_type;

   logic [DATA_W-1:0] reg_file [NUM_REGS];
   logic [DATA_W-1:0] data_mem [MEM_DEPTH];
   logic              stopped;
   retire_type        retire_q [$];
   int                errors;

   task automatic retire_instr(input logic [REQ_TDATA_W-1:0] word, input logic lit,
                               output retire_type res);
      logic [2:0]        op;
      logic [3:0]        tgt;
      logic [3:0]        first;
      logic [DATA_W-1:0] opv;
      logic [15:0]       addr;
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
      op    = word[2:0];
      tgt   = word[6:3];
      first = word[10:7];
      opv   = word[42:11];
      addr  = word[58:43];
      res.status = ST_DONE;
      res.value  = '0;
      if (stopped) begin
         res.status = ST_STOPPED;
      end else begin
         case (op)
            OP_ADD, OP_SUB: begin
               if (first > LAST_REG || (!lit && opv > LAST_REG) || tgt > LAST_REG) begin
                  res.status = ST_BAD_REG;
               end else begin
                  a = reg_file[first];
                  b = lit ? opv : reg_file[opv[3:0]];
                  res.value = (op == OP_ADD) ? a + b : a - b;
                  reg_file[tgt] = res.value;
               end
            end
            OP_LDR: begin
               if (addr >= MEM_DEPTH) begin
                  res.status = ST_BAD_ADDR;
               end else if (tgt > LAST_REG) begin
                  res.status = ST_BAD_REG;
               end else begin
                  res.value = data_mem[addr];
                  reg_file[tgt] = res.value;
               end
            end
            OP_STR: begin
               if (tgt > LAST_REG) begin
                  res.status = ST_BAD_REG;
               end else if (addr >= MEM_DEPTH) begin
                  res.status = ST_BAD_ADDR;
               end else begin
                  res.value = reg_file[tgt];
                  data_mem[addr] = res.value;
               end
            end
            OP_HALT: begin
               res.status = ST_HALTED;
               stopped = 1'b1;
            end
            default: ;
         endcase
         if (res.status == ST_BAD_REG || res.status == ST_BAD_ADDR) begin
            stopped   = 1'b1;
            res.value = '0;
         end
      end
   endtask

   always @(posedge clock) begin
      retire_type want;
      retire_type got;
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) reg_file[i] = DATA_W'(i);
         for (int i = 0; i < MEM_DEPTH; i++) data_mem[i] = '0;
         stopped = 1'b0;
         retire_q.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            retire_instr(req_tdata, req_tuser[0], want);
            retire_q.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.status = rsp_tdata[2:0];
            got.value  = rsp_tdata[34:3];
            if (retire_q.size() == 0) begin
               $display("%0t: unexpected rsp beat, status %0d value %h",
                        $time, got.status, got.value);
               errors++;
            end else begin
               want = retire_q.pop_front();
               if (got.status !== want.status) begin
                  $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
                  errors++;
               end
               if (got.value !== want.value) begin
                  $display("%0t: result_value expected %h got %h", $time, want.value, got.value);
                  errors++;
               end
            end
         end
      end
      mismatch_count <= errors;
      outstanding    <= retire_q.size();
   end

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps
// Top of the execute core testbench: clock, reset, instruction stimulus and rsp
// back-pressure, verdict. Needs trme_pkg, the core and trme_execute_checker.
module tb;
   import trme_pkg::*;

   localparam int RANDOM_ITEMS    = 1450;
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES   = 20;

   localparam logic [2:0] OP_SPARE_A = 3'd5;
   localparam logic [2:0] OP_SPARE_B = 3'd6;
   localparam logic [2:0] OP_SPARE_C = 3'd7;

   typedef enum int {
      STOP_HALT,
      STOP_BAD_FIRST,
      STOP_BAD_OPERAND,
      STOP_BAD_TARGET,
      STOP_LDR_ADDR,
      STOP_LDR_TARGET,
      STOP_STR_TARGET,
      STOP_STR_ADDR
   } stop_kind_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [0:0]             req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   int                     mismatch_count;
   int                     outstanding;
   bit                     no_idle    = 1'b0;
   bit                     drain_hold = 1'b0;

   tiny_register_machine_execute_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   trme_execute_checker retire_monitor (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("tiny_register_machine_execute_core test failed");
      $finish;
   end

   function automatic int pick_idle();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [3:0] rand_reg();
      return 4'($urandom_range(0, NUM_REGS - 1));
   endfunction

   function automatic logic [31:0] rand_literal();
      case ($urandom_range(0, 5))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 32'($urandom_range(0, 15));
         3: return 32'hffff_ffff - 32'($urandom_range(0, 15));
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [15:0] rand_addr();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 16'($urandom_range(0, 15));
      if (r < 90) return 16'($urandom_range(0, MEM_DEPTH - 1));
      return 16'(MEM_DEPTH - 1 - $urandom_range(0, 3));
   endfunction

   // rsp side: random stalls, plus one long hold-off on request
   initial begin : rsp_side
      while (reset) @(posedge clock);
      forever begin
         if (drain_hold) begin
            rsp_tready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            drain_hold = 1'b0;
         end else if (no_idle) begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_tready <= ($urandom_range(0, 3) != 0);
            repeat (pick_idle() + 1) @(posedge clock);
         end
      end
   end

   task automatic send_instr(input logic [2:0] op, input logic [3:0] tgt,
                             input logic [3:0] first, input logic lit,
                             input logic [31:0] opv, input logic [15:0] addr);
      int gap;
      gap = no_idle ? 0 : pick_idle();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {5'b0, addr, opv, first, tgt, op};
      req_tuser  <= lit;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // hold the sender until every result beat is back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic send_random(output bit is_instr);
      int   r;
      logic lit;
      r   = $urandom_range(0, 99);
      lit = 1'($urandom_range(0, 1));
      is_instr = 1'b1;
      if (r < 50) begin
         send_instr(r < 25 ? OP_ADD : OP_SUB, rand_reg(), rand_reg(), lit,
                    lit ? rand_literal() : 32'(rand_reg()), 16'($urandom));
      end else if (r < 90) begin
         send_instr(r < 70 ? OP_LDR : OP_STR, rand_reg(), 4'($urandom), lit,
                    $urandom, rand_addr());
      end else begin
         is_instr = 1'b0;
         send_instr(3'($urandom_range(OP_SPARE_A, OP_SPARE_C)), 4'($urandom),
                    4'($urandom), 1'($urandom), $urandom, 16'($urandom));
      end
   endtask

   task automatic send_any();
      send_instr(3'($urandom), 4'($urandom), 4'($urandom), 1'($urandom),
                 $urandom, 16'($urandom));
   endtask

   initial begin : stimulus
      int            n;
      int            counted;
      bit            took;
      stop_kind_type kind;
      logic [31:0]   bad_opv;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_instr(OP_ADD, 4'd0, 4'd11, 1'b1, 32'h7fff_ffff, 16'd0);
      send_instr(OP_ADD, 4'd1, 4'd1, 1'b1, 32'h8000_0000, 16'hffff);
      send_instr(OP_SUB, 4'd2, 4'd0, 1'b1, 32'hffff_ffff, 16'd0);
      send_instr(OP_ADD, 4'd3, 4'd11, 1'b0, 32'd10, 16'd0);
      send_instr(OP_SUB, 4'd4, 4'd3, 1'b0, 32'd3, 16'd0);
      send_instr(OP_SUB, 4'd5, 4'd8, 1'b0, 32'd0, 16'd0);
      send_instr(OP_STR, 4'd0, 4'd0, 1'b0, 32'd0, 16'd0);
      send_instr(OP_LDR, 4'd6, 4'd0, 1'b0, 32'd0, 16'd0);
      send_instr(OP_STR, 4'd1, 4'd15, 1'b1, 32'hffff_ffff, 16'(MEM_DEPTH - 1));
      send_instr(OP_LDR, 4'd7, 4'd15, 1'b1, 32'hffff_ffff, 16'(MEM_DEPTH - 1));
      send_instr(OP_LDR, 4'd8, 4'd0, 1'b0, 32'd0, 16'd100);
      send_instr(OP_ADD, 4'd9, 4'd9, 1'b1, 32'd0, 16'hffff);
      send_instr(OP_SPARE_A, 4'd15, 4'd15, 1'b1, 32'hffff_ffff, 16'hffff);
      send_instr(OP_SPARE_B, 4'd15, 4'd15, 1'b0, 32'hffff_ffff, 16'hffff);
      send_instr(OP_SPARE_C, 4'd0, 4'd0, 1'b0, 32'd0, 16'd0);
      send_instr(OP_ADD, 4'd11, 4'd11, 1'b0, 32'd11, 16'd0);
      send_instr(OP_STR, 4'd11, 4'd0, 1'b0, 32'd0, 16'd1);
      send_instr(OP_LDR, 4'd10, 4'd0, 1'b0, 32'd0, 16'd1);
      send_instr(OP_SUB, 4'd10, 4'd10, 1'b1, 32'd1, 16'd0);
      drain();

      counted = 0;
      n       = 0;
      while (counted < RANDOM_ITEMS) begin
         if (n % 200 == 100) no_idle = 1'b1;
         if (n % 200 == 160) no_idle = 1'b0;
         if (n == 500) drain_hold = 1'b1;
         if (n == 900) drain();
         send_random(took);
         if (took) counted++;
         n++;
      end
      no_idle = 1'b0;
      drain();

      // stop the machine once, then everything after it must come back with the stopped status
      kind = stop_kind_type'($urandom_range(0, 7));
      bad_opv = $urandom_range(0, 1) ? 32'($urandom_range(12, 1000))
                                     : ($urandom | 32'h8000_0000);
      case (kind)
         STOP_HALT:
            send_instr(OP_HALT, 4'($urandom), 4'($urandom), 1'($urandom), $urandom,
                       16'($urandom));
         STOP_BAD_FIRST:
            send_instr(OP_ADD, rand_reg(), 4'($urandom_range(12, 15)), 1'b1, $urandom,
                       16'($urandom));
         STOP_BAD_OPERAND:
            send_instr(OP_SUB, rand_reg(), rand_reg(), 1'b0, bad_opv, 16'($urandom));
         STOP_BAD_TARGET:
            send_instr(OP_ADD, 4'($urandom_range(12, 15)), rand_reg(), 1'b1, $urandom,
                       16'($urandom));
         STOP_LDR_ADDR:
            send_instr(OP_LDR, 4'($urandom), 4'($urandom), 1'($urandom), $urandom,
                       16'($urandom_range(MEM_DEPTH, 65535)));
         STOP_LDR_TARGET:
            send_instr(OP_LDR, 4'($urandom_range(12, 15)), 4'($urandom), 1'($urandom),
                       $urandom, rand_addr());
         STOP_STR_TARGET:
            send_instr(OP_STR, 4'($urandom_range(12, 15)), 4'($urandom), 1'($urandom),
                       $urandom, 16'($urandom));
         default:
            send_instr(OP_STR, rand_reg(), 4'($urandom), 1'($urandom), $urandom,
                       16'($urandom_range(MEM_DEPTH, 65535)));
      endcase
      repeat (20) send_any();
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && outstanding == 0)
         $display("tiny_register_machine_execute_core test passed");
      else
         $display("tiny_register_machine_execute_core test failed");
      $finish;
   end

endmodule
